/* rtl/cld_pkg.sv */
package cld_pkg;

    // Header key, matched case-insensitively
    localparam int unsigned PREFIX_LEN = 15;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic [31:0] CAPACITY_RESET = 32'd65536;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_DRAIN
    } phase_t;

    typedef enum logic [1:0] {
        NS_BEFORE,
        NS_DIGITS,
        NS_DONE,
        NS_DEAD
    } num_stage_t;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NO_LENGTH  = 2'd0,
        ERR_LINE_LONG  = 2'd1,
        ERR_TOO_LARGE  = 2'd2,
        ERR_TRUNCATED  = 2'd3
    } err_t;

    // Commands from the frame control to the line parser
    typedef enum logic [1:0] {
        PA_NONE,
        PA_FEED,
        PA_END_LINE,
        PA_CLEAR
    } parse_cmd_t;

    typedef struct packed {
        logic line_empty;
        logic line_full;
        logic len_valid;
    } parse_stat_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [31:0] frame_length;
        err_t        error_code;
    } result_t;

    function automatic logic [7:0] key_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = 8'h63; // c
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h6C; // l
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            4'd14:   c = 8'h3A; // :
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

endpackage

/* rtl/content_length_deframer_unit.sv */
// Content-Length deframer. Bytes enter on the s_ stream (s_tlast marks end
// of stream; its byte is ignored). Header lines end at LF, CR is dropped,
// and a line "Content-Length:" (any case), blanks, then digits sets the
// frame length, the last such line winning and the value saturating at
// LENGTH_WIDTH bits. A blank line ends the header; the block then streams
// the payload bytes (m_tlast on the final one), reports an empty frame,
// or reports an error: missing length, line of MAX_LINE characters,
// payload not below payload_capacity (drained silently, then reported),
// or stream ended before the payload was complete. Rate: one transfer per
// clock while m_tready allows; each byte is held in the input register
// and then resolved into the output register.
// payload_capacity sits at APB address 0 and resets to 65536; write it
// only while the block is idle.
module content_length_deframer_unit #(
    parameter int MAX_LINE     = 1024,
    parameter int LENGTH_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] in_byte
    input  logic                              s_tlast,   // end_of_stream
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [47:0]                       m_tdata,   // [7:0] data_byte,
                                                         // [39:8] frame_length,
                                                         // [41:40] error_code,
                                                         // [47:42] zero
    output logic [1:0]                        m_tuser,   // [1:0] kind
    output logic                              m_tlast,   // last_byte
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cld_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    // input register
    logic                      in_valid_reg;
    logic [7:0]                in_byte_reg;
    logic                      in_eos_reg;

    // output register
    logic                      out_valid_reg, out_valid_next;
    cld_pkg::result_t          out_reg;

    logic                      advance;
    logic [31:0]               capacity;
    cld_pkg::parse_cmd_t       cmd;
    cld_pkg::parse_stat_t      stat;
    logic [LENGTH_WIDTH-1:0]   eff_len;
    logic                      res_valid;
    cld_pkg::result_t          res;

    // The held byte moves on when the output register is free or drains now
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_eos_reg  <= s_tlast;
        end
    end

    cld_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    cld_line_parser #(
        .MAX_LINE     (MAX_LINE),
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .in_byte (in_byte_reg),
        .stat    (stat),
        .eff_len (eff_len)
    );

    cld_frame_ctrl #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_frame (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .in_byte   (in_byte_reg),
        .in_eos    (in_eos_reg),
        .capacity  (capacity),
        .stat      (stat),
        .eff_len   (eff_len),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = res_valid;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b000000, out_reg.error_code, out_reg.frame_length,
                       out_reg.data_byte};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last_byte;

endmodule

/* rtl/cld_cfg_regs.sv */
module cld_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cld_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output logic [31:0]                       capacity
);

    logic [31:0] capacity_reg;
    logic        sel_cap;

    // Word index is paddr[2]; only index 0 exists
    assign sel_cap  = (paddr[cld_pkg::CFG_ADDR_W-1] == 1'b0);
    assign pready   = 1'b1;
    assign prdata   = sel_cap ? capacity_reg : 32'd0;
    assign capacity = capacity_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= cld_pkg::CAPACITY_RESET;
        end else if (psel && penable && pwrite && pready && sel_cap) begin
            capacity_reg <= pwdata;
        end
    end

endmodule

/* rtl/cld_line_parser.sv */
module cld_line_parser #(
    parameter int MAX_LINE     = 1024,
    parameter int LENGTH_WIDTH = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  cld_pkg::parse_cmd_t         cmd,
    input  logic [7:0]                  in_byte,
    output cld_pkg::parse_stat_t        stat,
    output logic [LENGTH_WIDTH-1:0]     eff_len
);

    localparam int CNT_W = $clog2(MAX_LINE);
    localparam int ACC_W = LENGTH_WIDTH + 4;

    logic [CNT_W-1:0]          count_reg, count_next;
    logic [3:0]                pidx_reg, pidx_next;
    logic                      alive_reg, alive_next;
    cld_pkg::num_stage_t       ns_reg, ns_next;
    logic [LENGTH_WIDTH-1:0]   value_reg, value_next;
    logic [LENGTH_WIDTH-1:0]   hlen_reg, hlen_next;
    logic                      hvalid_reg, hvalid_next;

    logic                      is_digit;
    logic                      is_blank;
    logic [LENGTH_WIDTH-1:0]   digit_val;
    logic [ACC_W-1:0]          acc_ext;
    logic [ACC_W-1:0]          acc_sum;
    logic [LENGTH_WIDTH-1:0]   acc_sat;
    logic                      commit_ok;

    assign is_digit  = (in_byte >= cld_pkg::CHAR_ZERO) && (in_byte <= cld_pkg::CHAR_NINE);
    assign is_blank  = (in_byte == cld_pkg::CHAR_SPACE) || (in_byte == cld_pkg::CHAR_TAB);
    assign digit_val = LENGTH_WIDTH'(in_byte[3:0]);

    // value*10 + digit, saturating at all ones
    assign acc_ext = {4'b0000, value_reg};
    assign acc_sum = (acc_ext << 3) + (acc_ext << 1) + ACC_W'(in_byte[3:0]);
    assign acc_sat = (acc_sum[ACC_W-1:LENGTH_WIDTH] != 4'b0000) ? {LENGTH_WIDTH{1'b1}}
                                                                : acc_sum[LENGTH_WIDTH-1:0];

    assign commit_ok = alive_reg && (pidx_reg == 4'(cld_pkg::PREFIX_LEN)) &&
                       ((ns_reg == cld_pkg::NS_DIGITS) || (ns_reg == cld_pkg::NS_DONE));

    assign eff_len         = commit_ok ? value_reg : hlen_reg;
    assign stat.len_valid  = hvalid_reg || commit_ok;
    assign stat.line_empty = (count_reg == '0);
    assign stat.line_full  = (count_reg == CNT_W'(MAX_LINE - 1));

    always_comb begin
        count_next  = count_reg;
        pidx_next   = pidx_reg;
        alive_next  = alive_reg;
        ns_next     = ns_reg;
        value_next  = value_reg;
        hlen_next   = hlen_reg;
        hvalid_next = hvalid_reg;
        unique case (cmd)
            cld_pkg::PA_FEED: begin
                count_next = count_reg + 1'b1;
                if (alive_reg) begin
                    if (pidx_reg != 4'(cld_pkg::PREFIX_LEN)) begin
                        if (cld_pkg::to_lower(in_byte) == cld_pkg::key_char(pidx_reg)) begin
                            pidx_next = pidx_reg + 4'd1;
                        end else begin
                            alive_next = 1'b0;
                        end
                    end else begin
                        unique case (ns_reg)
                            cld_pkg::NS_BEFORE: begin
                                if (is_digit) begin
                                    value_next = digit_val;
                                    ns_next    = cld_pkg::NS_DIGITS;
                                end else if (!is_blank) begin
                                    ns_next = cld_pkg::NS_DEAD;
                                end
                            end
                            cld_pkg::NS_DIGITS: begin
                                if (is_digit) begin
                                    value_next = acc_sat;
                                end else begin
                                    ns_next = cld_pkg::NS_DONE;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            cld_pkg::PA_END_LINE: begin
                if (commit_ok) begin
                    hlen_next   = value_reg;
                    hvalid_next = 1'b1;
                end
                count_next = '0;
                pidx_next  = '0;
                alive_next = 1'b1;
                ns_next    = cld_pkg::NS_BEFORE;
                value_next = '0;
            end
            cld_pkg::PA_CLEAR: begin
                count_next  = '0;
                pidx_next   = '0;
                alive_next  = 1'b1;
                ns_next     = cld_pkg::NS_BEFORE;
                value_next  = '0;
                hlen_next   = '0;
                hvalid_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            pidx_reg   <= '0;
            alive_reg  <= 1'b1;
            ns_reg     <= cld_pkg::NS_BEFORE;
            value_reg  <= '0;
            hlen_reg   <= '0;
            hvalid_reg <= 1'b0;
        end else begin
            count_reg  <= count_next;
            pidx_reg   <= pidx_next;
            alive_reg  <= alive_next;
            ns_reg     <= ns_next;
            value_reg  <= value_next;
            hlen_reg   <= hlen_next;
            hvalid_reg <= hvalid_next;
        end
    end

endmodule

/* rtl/cld_frame_ctrl.sv */
module cld_frame_ctrl #(
    parameter int LENGTH_WIDTH = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step,
    input  logic [7:0]                  in_byte,
    input  logic                        in_eos,
    input  logic [31:0]                 capacity,
    input  cld_pkg::parse_stat_t        stat,
    input  logic [LENGTH_WIDTH-1:0]     eff_len,
    output cld_pkg::parse_cmd_t         cmd,
    output logic                        res_valid,
    output cld_pkg::result_t            res
);

    localparam int CMP_W = (LENGTH_WIDTH > 32) ? LENGTH_WIDTH : 32;

    cld_pkg::phase_t           phase_reg, phase_next;
    logic [LENGTH_WIDTH-1:0]   remain_reg, remain_next;
    logic [31:0]               flen_reg, flen_next;

    logic                      is_cr;
    logic                      is_lf;
    logic                      finish;
    logic [CMP_W-1:0]          len_ext;
    logic                      too_big;
    logic                      len_zero;
    logic                      rem_one;
    logic [31:0]               len32;

    assign is_cr    = (in_byte == cld_pkg::CHAR_CR);
    assign is_lf    = (in_byte == cld_pkg::CHAR_LF);
    assign finish   = in_eos || (is_lf && stat.line_empty);
    assign len_ext  = CMP_W'(eff_len);
    assign len32    = len_ext[31:0];
    assign too_big  = (len_ext >= CMP_W'(capacity));
    assign len_zero = (eff_len == '0);
    assign rem_one  = (remain_reg == LENGTH_WIDTH'(1));

    // next state
    always_comb begin
        phase_next  = phase_reg;
        remain_next = remain_reg;
        flen_next   = flen_reg;
        if (step) begin
            unique case (phase_reg)
                cld_pkg::PH_HEADER: begin
                    if (!is_cr && finish && stat.len_valid && !len_zero && !in_eos) begin
                        phase_next  = too_big ? cld_pkg::PH_DRAIN : cld_pkg::PH_PAYLOAD;
                        remain_next = eff_len;
                        flen_next   = len32;
                    end
                end
                cld_pkg::PH_PAYLOAD, cld_pkg::PH_DRAIN: begin
                    if (in_eos || rem_one) begin
                        phase_next  = cld_pkg::PH_HEADER;
                        remain_next = '0;
                    end else begin
                        remain_next = remain_reg - LENGTH_WIDTH'(1);
                    end
                end
                default: begin
                    phase_next = cld_pkg::PH_HEADER;
                end
            endcase
        end
    end

    // outputs
    always_comb begin
        cmd       = cld_pkg::PA_NONE;
        res_valid = 1'b0;
        res       = '0;
        if (step) begin
            unique case (phase_reg)
                cld_pkg::PH_HEADER: begin
                    priority if (finish) begin
                        cmd = cld_pkg::PA_CLEAR;
                        priority if (!stat.len_valid) begin
                            res_valid      = 1'b1;
                            res.kind       = cld_pkg::KIND_ERROR;
                            res.error_code = cld_pkg::ERR_NO_LENGTH;
                        end else if (too_big) begin
                            if (len_zero || in_eos) begin
                                res_valid        = 1'b1;
                                res.kind         = cld_pkg::KIND_ERROR;
                                res.frame_length = len32;
                                res.error_code   = cld_pkg::ERR_TOO_LARGE;
                            end
                        end else if (len_zero) begin
                            res_valid = 1'b1;
                            res.kind  = cld_pkg::KIND_EMPTY;
                        end else if (in_eos) begin
                            res_valid        = 1'b1;
                            res.kind         = cld_pkg::KIND_ERROR;
                            res.frame_length = len32;
                            res.error_code   = cld_pkg::ERR_TRUNCATED;
                        end else begin
                        end
                    end else if (is_cr) begin
                        cmd = cld_pkg::PA_NONE;
                    end else if (is_lf) begin
                        cmd = cld_pkg::PA_END_LINE;
                    end else if (stat.line_full) begin
                        cmd            = cld_pkg::PA_CLEAR;
                        res_valid      = 1'b1;
                        res.kind       = cld_pkg::KIND_ERROR;
                        res.error_code = cld_pkg::ERR_LINE_LONG;
                    end else begin
                        cmd = cld_pkg::PA_FEED;
                    end
                end
                cld_pkg::PH_PAYLOAD: begin
                    res_valid        = 1'b1;
                    res.frame_length = flen_reg;
                    if (in_eos) begin
                        cmd            = cld_pkg::PA_CLEAR;
                        res.kind       = cld_pkg::KIND_ERROR;
                        res.error_code = cld_pkg::ERR_TRUNCATED;
                    end else begin
                        res.kind      = cld_pkg::KIND_BYTE;
                        res.data_byte = in_byte;
                        res.last_byte = rem_one;
                        if (rem_one) begin
                            cmd = cld_pkg::PA_CLEAR;
                        end
                    end
                end
                cld_pkg::PH_DRAIN: begin
                    if (in_eos || rem_one) begin
                        cmd              = cld_pkg::PA_CLEAR;
                        res_valid        = 1'b1;
                        res.kind         = cld_pkg::KIND_ERROR;
                        res.frame_length = flen_reg;
                        res.error_code   = cld_pkg::ERR_TOO_LARGE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= cld_pkg::PH_HEADER;
            remain_reg <= '0;
            flen_reg   <= '0;
        end else begin
            phase_reg  <= phase_next;
            remain_reg <= remain_next;
            flen_reg   <= flen_next;
        end
    end

endmodule

/* tb/cld_frame_checker.sv */
// Watches both streams and the APB port, tracks the deframer state
// byte by byte and compares every result transfer with the oldest
// predicted frame event.
module cld_frame_checker #(
    parameter int                              LINE_LIMIT = 1024,
    parameter logic [cld_pkg::CFG_ADDR_W-1:0]  CAP_ADDR   = '0
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [7:0]                        s_tdata,
    input  logic                              s_tlast,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [47:0]                       m_tdata,
    input  logic [1:0]                        m_tuser,
    input  logic                              m_tlast,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cld_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    input  logic [31:0]                       prdata,
    input  logic                              pready,
    output int                                mismatches,
    output int                                events_due,
    output int                                events_checked
);
    import cld_pkg::*;

    localparam logic [63:0]         LEN_MAX  = 64'hFFFF_FFFF;
    localparam logic [8*15-1:0]     KEY_TEXT = "content-length:";

    result_t      frame_events[$];

    phase_t       ph;
    num_stage_t   nstage;
    int unsigned  line_chars;
    int unsigned  key_pos;
    logic         key_ok;
    logic [63:0]  line_num;
    logic [63:0]  hdr_len;
    logic         hdr_ok;
    logic [63:0]  remaining;
    logic [63:0]  cur_len;
    logic [63:0]  capacity;
    int           bad_count;
    int           seen_count;

    function void check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
        if (want !== got) begin
            bad_count++;
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h",
                     $time, what, want, got);
        end
    endfunction

    function void post_event(input kind_t k, input logic [7:0] b, input logic lst,
                             input logic [31:0] flen, input err_t code);
        result_t ev;
        ev.kind         = k;
        ev.data_byte    = b;
        ev.last_byte    = lst;
        ev.frame_length = flen;
        ev.error_code   = code;
        frame_events.push_back(ev);
    endfunction

    function void restart_line();
        line_chars = 0;
        key_pos    = 0;
        key_ok     = 1'b1;
        nstage     = NS_BEFORE;
        line_num   = '0;
    endfunction

    function void restart_header();
        restart_line();
        hdr_len   = '0;
        hdr_ok    = 1'b0;
        remaining = '0;
        ph        = PH_HEADER;
    endfunction

    // key match first, then blanks, then digits (saturating)
    function void scan_char(input logic [7:0] c);
        logic        is_digit;
        logic [7:0]  lc;
        logic [63:0] d;
        is_digit = (c >= CHAR_ZERO && c <= CHAR_NINE);
        lc       = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;   // A..Z
        d        = {56'd0, c - CHAR_ZERO};
        if (key_ok) begin
            if (key_pos < PREFIX_LEN) begin
                if (lc == KEY_TEXT[8*(PREFIX_LEN-1-key_pos) +: 8]) begin
                    key_pos++;
                end else begin
                    key_ok = 1'b0;
                end
            end else if (nstage == NS_BEFORE) begin
                if (is_digit) begin
                    line_num = d;
                    nstage   = NS_DIGITS;
                end else if (c != CHAR_SPACE && c != CHAR_TAB) begin
                    nstage = NS_DEAD;
                end
            end else if (nstage == NS_DIGITS) begin
                if (is_digit) begin
                    if (line_num > (LEN_MAX - d) / 64'd10) begin
                        line_num = LEN_MAX;
                    end else begin
                        line_num = line_num * 64'd10 + d;
                    end
                end else begin
                    nstage = NS_DONE;
                end
            end
        end
    endfunction

    function void take_line();
        if (key_ok && key_pos == PREFIX_LEN &&
            (nstage == NS_DIGITS || nstage == NS_DONE)) begin
            hdr_len = line_num;
            hdr_ok  = 1'b1;
        end
    endfunction

    function void close_header(input logic eos);
        logic [63:0] len;
        len = hdr_len;
        if (!hdr_ok) begin
            restart_header();
            post_event(KIND_ERROR, 8'd0, 1'b0, 32'd0, ERR_NO_LENGTH);
        end else begin
            restart_header();
            cur_len = len;
            if (len >= capacity) begin
                if (len == 0 || eos) begin
                    post_event(KIND_ERROR, 8'd0, 1'b0, len[31:0], ERR_TOO_LARGE);
                end else begin
                    ph        = PH_DRAIN;
                    remaining = len;
                end
            end else if (len == 0) begin
                post_event(KIND_EMPTY, 8'd0, 1'b0, 32'd0, ERR_NO_LENGTH);
            end else if (eos) begin
                post_event(KIND_ERROR, 8'd0, 1'b0, len[31:0], ERR_TRUNCATED);
            end else begin
                ph        = PH_PAYLOAD;
                remaining = len;
            end
        end
    endfunction

    function void deframe_byte(input logic [7:0] b, input logic eos);
        logic lst;
        case (ph)
            PH_PAYLOAD: begin
                if (eos) begin
                    restart_header();
                    post_event(KIND_ERROR, 8'd0, 1'b0, cur_len[31:0], ERR_TRUNCATED);
                end else begin
                    remaining = remaining - 64'd1;
                    lst = (remaining == 0);
                    if (lst) begin
                        restart_header();
                    end
                    post_event(KIND_BYTE, b, lst, cur_len[31:0], ERR_NO_LENGTH);
                end
            end
            PH_DRAIN: begin
                if (!eos) begin
                    remaining = remaining - 64'd1;
                end
                if (eos || remaining == 0) begin
                    restart_header();
                    post_event(KIND_ERROR, 8'd0, 1'b0, cur_len[31:0], ERR_TOO_LARGE);
                end
            end
            default: begin
                if (eos) begin
                    take_line();
                    close_header(1'b1);
                end else if (b == CHAR_CR) begin
                    // dropped
                end else if (b == CHAR_LF) begin
                    if (line_chars == 0) begin
                        close_header(1'b0);
                    end else begin
                        take_line();
                        restart_line();
                    end
                end else if (line_chars + 1 >= LINE_LIMIT) begin
                    restart_header();
                    post_event(KIND_ERROR, 8'd0, 1'b0, 32'd0, ERR_LINE_LONG);
                end else begin
                    line_chars++;
                    scan_char(b);
                end
            end
        endcase
    endfunction

    function void check_result();
        result_t ev;
        if (frame_events.size() == 0) begin
            bad_count++;
            $display("%0t: unexpected result: expected none, got kind %0d tdata 0x%0h",
                     $time, m_tuser, m_tdata);
        end else begin
            ev = frame_events.pop_front();
            check_field("kind", ev.kind, m_tuser);
            check_field("data_byte", ev.data_byte, m_tdata[7:0]);
            check_field("last_byte", ev.last_byte, m_tlast);
            check_field("frame_length", ev.frame_length, m_tdata[39:8]);
            check_field("error_code", ev.error_code, m_tdata[41:40]);
            check_field("tdata pad", 32'd0, m_tdata[47:42]);
        end
        seen_count++;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            frame_events.delete();
            restart_header();
            cur_len    = '0;
            capacity   = {32'd0, CAPACITY_RESET};
            bad_count  = 0;
            seen_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_result();
            end
            if (s_tvalid && s_tready) begin
                deframe_byte(s_tdata, s_tlast);
            end
            if (psel && penable && pready && paddr == CAP_ADDR) begin
                if (pwrite) begin
                    capacity = {32'd0, pwdata};
                end else begin
                    check_field("prdata", capacity[31:0], prdata);
                end
            end
        end
        mismatches     <= bad_count;
        events_due     <= frame_events.size();
        events_checked <= seen_count;
    end

endmodule

/* tb/tb_content_length_deframer_unit.sv */
// Top of the deframer bench: clock, reset, byte stimulus, APB writes and
// the verdict. All prediction and comparison lives in cld_frame_checker.
module tb_content_length_deframer_unit;
    import cld_pkg::*;

    localparam int                      LINE_LIMIT  = 1024;
    localparam logic [CFG_ADDR_W-1:0]   CAP_ADDR    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0]   UNUSED_ADDR = 3'd4;   // no register here
    localparam int                      PHASE_ITEMS = 200;

    logic           aclk     = 1'b0;
    logic           aresetn  = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [7:0]     s_tdata  = 8'd0;
    logic           s_tlast  = 1'b0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [47:0]    m_tdata;
    logic [1:0]     m_tuser;
    logic           m_tlast;
    logic           psel     = 1'b0;
    logic           penable  = 1'b0;
    logic           pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr  = '0;
    logic [31:0]    pwdata   = 32'd0;
    logic [31:0]    prdata;
    logic           pready;

    int             fail_count;
    int             events_due;
    int             events_checked;

    int             send_gap_pct = 0;     // sender idle chance per cycle
    int             stall_pct    = 0;     // receiver stall chance per cycle
    int             items_sent   = 0;
    longint unsigned cap_now     = 65536;

    content_length_deframer_unit #(
        .MAX_LINE     (LINE_LIMIT),
        .LENGTH_WIDTH (32)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    cld_frame_checker #(
        .LINE_LIMIT (LINE_LIMIT),
        .CAP_ADDR   (CAP_ADDR)
    ) checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .mismatches     (fail_count),
        .events_due     (events_due),
        .events_checked (events_checked)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Receiver: one fresh ready decision per cycle.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #4000000;
        $display("timeout: results still outstanding: %0d", events_due);
        $display("tb: failure");
        $finish;
    end

    // One byte transfer; tvalid stays high into the next call unless a gap is drawn.
    task automatic send_item(input logic [7:0] b, input logic eos);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eos;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_text(input string t);
        int i;
        for (i = 0; i < t.len(); i++) begin
            send_item(t[i], 1'b0);
        end
    endtask

    task automatic send_eol();
        if ($urandom_range(0, 1)) begin
            send_item(CHAR_CR, 1'b0);
        end
        send_item(CHAR_LF, 1'b0);
    endtask

    task automatic send_blanks();
        repeat ($urandom_range(0, 2)) begin
            send_item($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB, 1'b0);
        end
    endtask

    // Header key with every letter in random case; optionally one char broken.
    task automatic send_key(input bit spoil);
        string      key;
        int         i;
        int         bad_pos;
        logic [7:0] c;
        key     = "content-length:";
        bad_pos = spoil ? $urandom_range(0, key.len() - 1) : -1;
        for (i = 0; i < key.len(); i++) begin
            c = key[i];
            if (i == bad_pos) begin
                c = "x";
            end else if (c >= "a" && c <= "z" && $urandom_range(0, 1)) begin
                c = c - 8'd32;
            end
            send_item(c, 1'b0);
        end
    endtask

    // A valid length line. big marks lengths whose payload is never sent whole.
    task automatic send_length_line(output longint unsigned decl, output bit big);
        int    pick;
        string digits;
        send_key(1'b0);
        send_blanks();
        pick = $urandom_range(0, 99);
        big  = 1'b0;
        if (pick < 8) begin
            // ten to fourteen digits, often past 32 bits and then saturating
            digits = $sformatf("%0d", $urandom_range(1, 9));
            repeat ($urandom_range(9, 13)) begin
                digits = {digits, $sformatf("%0d", $urandom_range(0, 9))};
            end
            decl = 64'hFFFF_FFFF;
            big  = 1'b1;
        end else if (pick < 12) begin
            // around the saturation point
            decl   = 64'hFFFF_FFFE + $urandom_range(0, 2);
            digits = $sformatf("%0d", decl);
            big    = 1'b1;
        end else if (pick < 18) begin
            decl   = $urandom;
            digits = $sformatf("%0d", decl);
            big    = (decl > 64);
        end else begin
            if (cap_now <= 64) begin
                decl = $urandom_range(0, int'(cap_now) + 3);
            end else begin
                decl = $urandom_range(0, 20);
            end
            digits = $sformatf("%0d", decl);
        end
        if ($urandom_range(0, 9) == 0) begin
            digits = {"00", digits};
        end
        send_text(digits);
        if ($urandom_range(0, 4) == 0) begin
            send_text(" ;q=1");      // junk after the digits is ignored
        end
        send_eol();
    endtask

    // Lines that never set the length.
    task automatic send_junk_line();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0: send_text("Content-Type: text/plain");
            1: begin
                repeat ($urandom_range(1, 12)) begin
                    c = 8'($urandom);
                    send_item((c == CHAR_LF) ? 8'h7E : c, 1'b0);
                end
            end
            2: begin
                // key matches but no digit follows the blanks
                send_key(1'b0);
                send_blanks();
                if ($urandom_range(0, 1)) begin
                    send_text("+12");
                end
            end
            default: begin
                send_key(1'b1);
                send_text(" 7");
            end
        endcase
        send_eol();
    endtask

    // One frame, mostly well formed; some end the stream early.
    task automatic send_frame();
        longint unsigned decl;
        longint unsigned next_decl;
        bit              big;
        bit              next_big;
        bit              have_len;
        int              fate;
        int              n;
        have_len = 1'b0;
        big      = 1'b0;
        decl     = 0;
        repeat ($urandom_range(0, 2)) send_junk_line();
        if ($urandom_range(0, 99) < 88) begin
            send_length_line(decl, big);
            have_len = 1'b1;
            if ($urandom_range(0, 99) < 15) begin
                // a second length line overrides the first
                send_length_line(next_decl, next_big);
                decl = next_decl;
                big  = next_big;
            end
        end
        if ($urandom_range(0, 99) < 25) begin
            send_junk_line();
        end
        fate = $urandom_range(0, 99);
        if (fate < 7) begin
            send_item(8'($urandom), 1'b1);             // stream ends in the header
        end else begin
            send_eol();                                // blank line
            if (have_len) begin
                n = int'(decl);
                if (big) begin
                    repeat ($urandom_range(0, 4)) send_item(8'($urandom), 1'b0);
                    send_item(8'($urandom), 1'b1);
                end else if (fate < 17) begin
                    repeat ((n > 0) ? $urandom_range(0, n - 1) : 0) begin
                        send_item(8'($urandom), 1'b0);
                    end
                    send_item(8'($urandom), 1'b1);
                end else begin
                    repeat (n) send_item(8'($urandom), 1'b0);
                end
            end
        end
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 8)) begin
            send_item(8'($urandom), ($urandom_range(0, 19) == 0));
        end
    endtask

    // 1023 counted characters are legal, the next one overflows the line.
    // CRs are mixed in; they do not count.
    task automatic send_long_line();
        int         counted;
        logic [7:0] c;
        counted = 0;
        while (counted < LINE_LIMIT) begin
            c = 8'($urandom);
            if (c == CHAR_CR) begin
                send_item(c, 1'b0);
            end else if (c != CHAR_LF) begin
                send_item(c, 1'b0);
                counted++;
            end
        end
    endtask

    task automatic apb_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                              input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Drop tvalid, wait for every predicted result, then let the pipe empty
    // (bytes that make no result leave nothing to wait on).
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (events_due != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    initial begin
        int stage;
        int stop_at;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset capacity, missing length by blank line and by end
        // of stream, CR dropped, zero length giving an empty frame.
        apb_access(1'b0, CAP_ADDR, 32'd0);
        send_item(CHAR_LF, 1'b0);
        send_item(8'hFF, 1'b1);
        send_item(CHAR_CR, 1'b0);
        send_item(CHAR_LF, 1'b0);
        send_text("CONTENT-length:\t0\r\n\n");
        send_item(8'h00, 1'b1);

        for (stage = 0; stage < 4; stage++) begin
            settle();
            case (stage)
                0: begin
                    cap_now      = 2;
                    send_gap_pct = 0;
                    stall_pct    = 0;
                end
                1: begin
                    cap_now      = 64'hFFFF_FFFF;
                    send_gap_pct = 60;
                    stall_pct    = 0;
                end
                2: begin
                    cap_now      = $urandom_range(3, 24);
                    send_gap_pct = 0;
                    stall_pct    = 60;
                end
                default: begin
                    // write to an address with no register: must change nothing
                    apb_access(1'b1, UNUSED_ADDR, $urandom);
                    cap_now      = $urandom_range(2, 64);
                    send_gap_pct = 23;
                    stall_pct    = 23;
                end
            endcase
            apb_access(1'b1, CAP_ADDR, cap_now[31:0]);
            apb_access(1'b0, CAP_ADDR, 32'd0);
            if (stage == 0) begin
                send_long_line();
            end
            stop_at = items_sent + PHASE_ITEMS;
            while (items_sent < stop_at) begin
                if ($urandom_range(0, 99) < 6) begin
                    send_noise();
                end else begin
                    send_frame();
                end
            end
        end
        settle();

        $display("summary: %0d byte transfers sent, %0d result transfers checked",
                 items_sent, events_checked);
        $display("summary: reset capacity plus four written settings, idling off/on");
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/cld_pkg.sv
rtl/cld_cfg_regs.sv
rtl/cld_line_parser.sv
rtl/cld_frame_ctrl.sv
rtl/content_length_deframer_unit.sv
tb/cld_frame_checker.sv
tb/tb_content_length_deframer_unit.sv
